@@ rtl/pgf_pkg.sv @@
`default_nettype none
package pgf_pkg;

    localparam int MAX_PROCS   = 1024;
    localparam int EXTENT_BITS = 24;

    localparam int EXT_W  = EXTENT_BITS;
    localparam int CNT_W  = 11;
    localparam int RANK_W = 10;

    // shared multiplier operand widths
    localparam int MUL_A_W = (2 * EXT_W > CNT_W) ? 2 * EXT_W : CNT_W;
    localparam int MUL_B_W = (EXT_W > CNT_W) ? EXT_W : CNT_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // three area terms, each a face product times a grid count
    localparam int COST_W = 2 * EXT_W + CNT_W + 2;

    localparam int DIV_CNT_W = $clog2(CNT_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;
    localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(256);

    localparam int IN_FIELDS_W  = CNT_W + RANK_W;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 9 * CNT_W + 3 * RANK_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_W - OUT_FIELDS_W;

    localparam logic [CNT_W-1:0] NO_NEIGHBOR = '1;

    typedef struct packed {
        logic [CNT_W-1:0]  grid_x;
        logic [CNT_W-1:0]  grid_y;
        logic [CNT_W-1:0]  grid_z;
        logic [RANK_W-1:0] pos_x;
        logic [RANK_W-1:0] pos_y;
        logic [RANK_W-1:0] pos_z;
        logic [CNT_W-1:0]  next_x;
        logic [CNT_W-1:0]  prev_x;
        logic [CNT_W-1:0]  next_y;
        logic [CNT_W-1:0]  prev_y;
        logic [CNT_W-1:0]  next_z;
        logic [CNT_W-1:0]  prev_z;
    } pgf_result_t;

endpackage
`default_nettype wire

@@ rtl/pgf_div.sv @@
`default_nettype none
module pgf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pgf_pkg::CNT_W-1:0] dividend,
    input  logic [pgf_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [pgf_pkg::CNT_W-1:0] quot,
    output logic [pgf_pkg::CNT_W-1:0] remd
);
    import pgf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           fit;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quot_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fit   = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[CNT_W-2:0], fit};
            rem_next  = fit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign remd = rem_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");
    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");
`endif

endmodule
`default_nettype wire

@@ rtl/pgf_mul.sv @@
`default_nettype none
module pgf_mul (
    input  logic                        clk,
    input  logic [pgf_pkg::MUL_A_W-1:0] a,
    input  logic [pgf_pkg::MUL_B_W-1:0] b,
    output logic [pgf_pkg::MUL_P_W-1:0] p
);
    import pgf_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    // product registered
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

@@ rtl/pgf_seq.sv @@
`default_nettype none
module pgf_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pgf_pkg::CNT_W-1:0]  count_in,
    input  logic [pgf_pkg::RANK_W-1:0] rank_in,
    input  logic [pgf_pkg::EXT_W-1:0]  ext_x,
    input  logic [pgf_pkg::EXT_W-1:0]  ext_y,
    input  logic [pgf_pkg::EXT_W-1:0]  ext_z,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_ready,
    output pgf_pkg::pgf_result_t       res
);
    import pgf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PA    = 5'd1;
    localparam logic [4:0] S_PB    = 5'd2;
    localparam logic [4:0] S_PC    = 5'd3;
    localparam logic [4:0] S_PD    = 5'd4;
    localparam logic [4:0] S_XDIV  = 5'd5;
    localparam logic [4:0] S_XWAIT = 5'd6;
    localparam logic [4:0] S_YDIV  = 5'd7;
    localparam logic [4:0] S_YWAIT = 5'd8;
    localparam logic [4:0] S_C0    = 5'd9;
    localparam logic [4:0] S_C1    = 5'd10;
    localparam logic [4:0] S_C2    = 5'd11;
    localparam logic [4:0] S_C3    = 5'd12;
    localparam logic [4:0] S_SLAB0 = 5'd13;
    localparam logic [4:0] S_SLAB1 = 5'd14;
    localparam logic [4:0] S_D1    = 5'd15;
    localparam logic [4:0] S_D1W   = 5'd16;
    localparam logic [4:0] S_D2    = 5'd17;
    localparam logic [4:0] S_D2W   = 5'd18;
    localparam logic [4:0] S_M0    = 5'd19;
    localparam logic [4:0] S_M1    = 5'd20;
    localparam logic [4:0] S_M2    = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       have_reg, have_next;

    logic [CNT_W-1:0]  n_reg, n_next;
    logic [RANK_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0]  ix_reg, ix_next;
    logic [CNT_W-1:0]  iy_reg, iy_next;
    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  iz_reg, iz_next;
    logic [CNT_W-1:0]  gx_reg, gx_next;
    logic [CNT_W-1:0]  gy_reg, gy_next;
    logic [CNT_W-1:0]  gz_reg, gz_next;
    logic [COST_W-1:0] acc_reg, acc_next;
    logic [COST_W-1:0] best_reg, best_next;
    logic [COST_W-1:0] axy_reg, axy_next;
    logic [COST_W-1:0] axz_reg, axz_next;
    logic [COST_W-1:0] ayz_reg, ayz_next;
    logic [CNT_W-1:0]  slab_reg, slab_next;
    logic [RANK_W-1:0] rs_reg, rs_next;
    logic [RANK_W-1:0] px_reg, px_next;
    logic [RANK_W-1:0] py_reg, py_next;
    logic [RANK_W-1:0] pz_reg, pz_next;
    logic [CNT_W-1:0]  wy_reg, wy_next;
    logic [CNT_W-1:0]  wz_reg, wz_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [COST_W-1:0]  prod;
    logic [COST_W-1:0]  cost;

    logic             div_start;
    logic [CNT_W-1:0] div_num;
    logic [CNT_W-1:0] div_den;
    logic             div_done;
    logic [CNT_W-1:0] div_q;
    logic [CNT_W-1:0] div_r;

    logic [CNT_W-1:0] n_sat;
    logic [CNT_W-1:0] n_sat_m1;
    logic             last_x;
    logic             last_y;

    pgf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pgf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (div_q),
        .remd     (div_r)
    );

    assign prod = COST_W'(mul_p);
    assign cost = acc_reg + prod;

    always_comb
    begin
        if (count_in == '0)
            n_sat = CNT_W'(1);
        else if (count_in > CNT_W'(MAX_PROCS))
            n_sat = CNT_W'(MAX_PROCS);
        else
            n_sat = count_in;
    end
    assign n_sat_m1 = n_sat - 1'b1;

    assign last_x = ix_reg == n_reg;
    assign last_y = iy_reg == quo_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PA:
            begin
                mul_a = MUL_A_W'(ext_x);
                mul_b = MUL_B_W'(ext_y);
            end
            S_PB:
            begin
                mul_a = MUL_A_W'(ext_x);
                mul_b = MUL_B_W'(ext_z);
            end
            S_PC:
            begin
                mul_a = MUL_A_W'(ext_y);
                mul_b = MUL_B_W'(ext_z);
            end
            S_C0:
            begin
                mul_a = MUL_A_W'(axy_reg);
                mul_b = MUL_B_W'(iz_reg);
            end
            S_C1:
            begin
                mul_a = MUL_A_W'(axz_reg);
                mul_b = MUL_B_W'(iy_reg);
            end
            S_C2:
            begin
                mul_a = MUL_A_W'(ayz_reg);
                mul_b = MUL_B_W'(ix_reg);
            end
            S_SLAB0:
            begin
                mul_a = MUL_A_W'(gx_reg);
                mul_b = MUL_B_W'(gy_reg);
            end
            S_M0:
            begin
                mul_a = MUL_A_W'(gx_reg);
                mul_b = MUL_B_W'(gy_reg - 1'b1);
            end
            S_M1:
            begin
                mul_a = MUL_A_W'(slab_reg);
                mul_b = MUL_B_W'(gz_reg - 1'b1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = CNT_W'(1);
        case (state_reg)
            S_XDIV:
            begin
                div_start = 1'b1;
                div_num   = n_reg;
                div_den   = ix_reg;
            end
            S_YDIV:
            begin
                div_start = 1'b1;
                div_num   = quo_reg;
                div_den   = iy_reg;
            end
            S_D1:
            begin
                div_start = 1'b1;
                div_num   = CNT_W'(r_reg);
                div_den   = slab_reg;
            end
            S_D2:
            begin
                div_start = 1'b1;
                div_num   = CNT_W'(rs_reg);
                div_den   = gx_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        have_next  = have_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        quo_next   = quo_reg;
        iz_next    = iz_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        gz_next    = gz_reg;
        acc_next   = acc_reg;
        best_next  = best_reg;
        axy_next   = axy_reg;
        axz_next   = axz_reg;
        ayz_next   = ayz_reg;
        slab_next  = slab_reg;
        rs_next    = rs_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        wy_next    = wy_reg;
        wz_next    = wz_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = n_sat;
                    if (CNT_W'(rank_in) >= n_sat)
                        r_next = RANK_W'(n_sat_m1);
                    else
                        r_next = rank_in;
                    state_next = S_PA;
                end
            end
            S_PA:
                state_next = S_PB;
            S_PB:
            begin
                axy_next   = prod;
                state_next = S_PC;
            end
            S_PC:
            begin
                axz_next   = prod;
                state_next = S_PD;
            end
            S_PD:
            begin
                ayz_next   = prod;
                ix_next    = CNT_W'(1);
                have_next  = 1'b0;
                state_next = S_XDIV;
            end
            S_XDIV:
                state_next = S_XWAIT;
            S_XWAIT:
            begin
                if (div_done)
                begin
                    if (div_r == '0)
                    begin
                        quo_next   = div_q;
                        iy_next    = CNT_W'(1);
                        state_next = S_YDIV;
                    end
                    else if (last_x)
                        state_next = S_SLAB0;
                    else
                    begin
                        ix_next    = ix_reg + 1'b1;
                        state_next = S_XDIV;
                    end
                end
            end
            S_YDIV:
                state_next = S_YWAIT;
            S_YWAIT:
            begin
                if (div_done)
                begin
                    if (div_r == '0)
                    begin
                        iz_next    = div_q;
                        state_next = S_C0;
                    end
                    else if (!last_y)
                    begin
                        iy_next    = iy_reg + 1'b1;
                        state_next = S_YDIV;
                    end
                    else if (last_x)
                        state_next = S_SLAB0;
                    else
                    begin
                        ix_next    = ix_reg + 1'b1;
                        state_next = S_XDIV;
                    end
                end
            end
            S_C0:
                state_next = S_C1;
            S_C1:
            begin
                acc_next   = prod;
                state_next = S_C2;
            end
            S_C2:
            begin
                acc_next   = cost;
                state_next = S_C3;
            end
            S_C3:
            begin
                // strict improvement only, so the first minimum is kept
                if (!have_reg || (cost < best_reg))
                begin
                    have_next = 1'b1;
                    best_next = cost;
                    gx_next   = ix_reg;
                    gy_next   = iy_reg;
                    gz_next   = iz_reg;
                end
                if (!last_y)
                begin
                    iy_next    = iy_reg + 1'b1;
                    state_next = S_YDIV;
                end
                else if (last_x)
                    state_next = S_SLAB0;
                else
                begin
                    ix_next    = ix_reg + 1'b1;
                    state_next = S_XDIV;
                end
            end
            S_SLAB0:
                state_next = S_SLAB1;
            S_SLAB1:
            begin
                slab_next  = CNT_W'(mul_p);
                state_next = S_D1;
            end
            S_D1:
                state_next = S_D1W;
            S_D1W:
            begin
                if (div_done)
                begin
                    pz_next    = RANK_W'(div_q);
                    rs_next    = RANK_W'(div_r);
                    state_next = S_D2;
                end
            end
            S_D2:
                state_next = S_D2W;
            S_D2W:
            begin
                // slab is a multiple of gx, so this remainder is rank mod gx
                if (div_done)
                begin
                    py_next    = RANK_W'(div_q);
                    px_next    = RANK_W'(div_r);
                    state_next = S_M0;
                end
            end
            S_M0:
                state_next = S_M1;
            S_M1:
            begin
                wy_next    = CNT_W'(mul_p);
                state_next = S_M2;
            end
            S_M2:
            begin
                wz_next    = CNT_W'(mul_p);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        r_reg    <= r_next;
        ix_reg   <= ix_next;
        iy_reg   <= iy_next;
        quo_reg  <= quo_next;
        iz_reg   <= iz_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        gz_reg   <= gz_next;
        acc_reg  <= acc_next;
        best_reg <= best_next;
        axy_reg  <= axy_next;
        axz_reg  <= axz_next;
        ayz_reg  <= ayz_next;
        slab_reg <= slab_next;
        rs_reg   <= rs_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        wy_reg   <= wy_next;
        wz_reg   <= wz_next;
    end

    // periodic neighbors, all in 11-bit wrapping arithmetic
    logic [CNT_W-1:0] r_w;
    logic [CNT_W-1:0] px_w;
    logic [CNT_W-1:0] py_w;
    logic [CNT_W-1:0] pz_w;

    assign r_w  = CNT_W'(r_reg);
    assign px_w = CNT_W'(px_reg);
    assign py_w = CNT_W'(py_reg);
    assign pz_w = CNT_W'(pz_reg);

    always_comb
    begin
        res.grid_x = gx_reg;
        res.grid_y = gy_reg;
        res.grid_z = gz_reg;
        res.pos_x  = px_reg;
        res.pos_y  = py_reg;
        res.pos_z  = pz_reg;
        if (gx_reg > CNT_W'(1))
        begin
            res.next_x = (px_w < gx_reg - 1'b1) ? r_w + 1'b1 : r_w - (gx_reg - 1'b1);
            res.prev_x = (px_w > '0) ? r_w - 1'b1 : r_w + (gx_reg - 1'b1);
        end
        else
        begin
            res.next_x = NO_NEIGHBOR;
            res.prev_x = NO_NEIGHBOR;
        end
        if (gy_reg > CNT_W'(1))
        begin
            res.next_y = (py_w < gy_reg - 1'b1) ? r_w + gx_reg : r_w - wy_reg;
            res.prev_y = (py_w > '0) ? r_w - gx_reg : r_w + wy_reg;
        end
        else
        begin
            res.next_y = NO_NEIGHBOR;
            res.prev_y = NO_NEIGHBOR;
        end
        if (gz_reg > CNT_W'(1))
        begin
            res.next_z = (pz_w < gz_reg - 1'b1) ? r_w + slab_reg : r_w - wz_reg;
            res.prev_z = (pz_w > '0) ? r_w - slab_reg : r_w + wz_reg;
        end
        else
        begin
            res.next_z = NO_NEIGHBOR;
            res.prev_z = NO_NEIGHBOR;
        end
    end

    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;

`ifndef NO_ASSERTIONS
    a_grid_product: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((33'(gx_reg) * 33'(gy_reg) * 33'(gz_reg)) == 33'(n_reg)))
        else $error("chosen grid does not multiply to the process count");
    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (px_w < gx_reg) && (py_w < gy_reg) && (pz_w < gz_reg))
        else $error("position outside chosen grid");
    a_ix_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_XWAIT || state_reg == S_YWAIT || state_reg == S_C3)
        |-> (ix_reg >= CNT_W'(1)) && (ix_reg <= n_reg))
        else $error("search index out of range");
    a_iy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YWAIT || state_reg == S_C3)
        |-> (iy_reg >= CNT_W'(1)) && (iy_reg <= quo_reg))
        else $error("inner search index out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/proc_grid_factor_and_torus_neighbors.sv @@
`default_nettype none
// Splits a process count into a 3d grid gx*gy*gz that minimizes the total
// sub-domain face area for the configured domain extents (first strict
// minimum with gx, then gy ascending), and reports the rank's x-fastest
// position plus its six periodic neighbor ranks (all ones where an axis
// has a single process). Counts of zero read as 1, counts above 1024 as
// 1024, and a rank at or above the count is clamped to count-1. One item
// is worked at a time and s_axis_tready is low meanwhile. Every divisor
// test goes through one shared 11-step restoring divider and each
// candidate cost is formed on the shared multiplier. The extents are
// written through the cfg port (index 0, 1, 2 for x, y, z; other indexes
// are ignored); the user must write them only while the block is idle,
// which the block itself does not enforce.
module proc_grid_factor_and_torus_neighbors (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // proc_count[10:0], rank[20:11], zero pad
    input  logic [pgf_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // grid_x, grid_y, grid_z, pos_x, pos_y, pos_z, next_x, prev_x,
    // next_y, prev_y, next_z, prev_z, zero pad
    output logic [pgf_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pgf_pkg::EXT_W-1:0]     cfg_data
);
    import pgf_pkg::*;

    logic [EXT_W-1:0] ext_x_reg;
    logic [EXT_W-1:0] ext_y_reg;
    logic [EXT_W-1:0] ext_z_reg;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic        seq_idle;
    logic        seq_start;
    logic        res_valid;
    logic        res_ready;
    pgf_result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg <= EXT_RESET;
            ext_y_reg <= EXT_RESET;
            ext_z_reg <= EXT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXTENT_X: ext_x_reg <= cfg_data;
                REG_EXTENT_Y: ext_y_reg <= cfg_data;
                REG_EXTENT_Z: ext_z_reg <= cfg_data;
                default:      ext_x_reg <= ext_x_reg;
            endcase
        end
    end

    assign s_axis_tready = seq_idle;
    assign seq_start     = s_axis_tvalid && s_axis_tready;

    pgf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .count_in  (s_axis_tdata[CNT_W-1:0]),
        .rank_in   (s_axis_tdata[CNT_W+RANK_W-1:CNT_W]),
        .ext_x     (ext_x_reg),
        .ext_y     (ext_y_reg),
        .ext_z     (ext_z_reg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register frees the sequencer as soon as a result is taken
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{OUT_PAD_W{1'b0}},
                              res.prev_z, res.next_z, res.prev_y, res.next_y,
                              res.prev_x, res.next_x,
                              res.pos_z, res.pos_y, res.pos_x,
                              res.grid_z, res.grid_y, res.grid_x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pgf_pkg::*;

    localparam int NB_BASE     = 3 * CNT_W + 3 * RANK_W;
    localparam int IDLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS    = 23;
    localparam int BATCH_ITEMS = 13;
    localparam int EXT_PHASES  = 6;

    // index past the last extent register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [EXT_W-1:0]     EXT_MAX    = '1;

    localparam pgf_result_t LONE_PROC = pgf_result_t'({CNT_W'(1), CNT_W'(1), CNT_W'(1),
        RANK_W'(0), RANK_W'(0), RANK_W'(0), {6{NO_NEIGHBOR}}});
    // two processes stacked along z, rank 1 on top
    localparam pgf_result_t PAIR_TOP = pgf_result_t'({CNT_W'(1), CNT_W'(1), CNT_W'(2),
        RANK_W'(0), RANK_W'(0), RANK_W'(1), {4{NO_NEIGHBOR}}, CNT_W'(0), CNT_W'(0)});
    localparam pgf_result_t UNTYPED = '0;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [RANK_W-1:0] rank;
        logic              typed;
        pgf_result_t       want;
    } dir_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [EXT_W-1:0]     cfg_data      = '0;

    // extents as the block should hold them
    logic [EXT_W-1:0] ext_x = EXT_RESET;
    logic [EXT_W-1:0] ext_y = EXT_RESET;
    logic [EXT_W-1:0] ext_z = EXT_RESET;

    pgf_result_t grids_pending[$];
    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        {11'd1,    10'd0,    1'b1, LONE_PROC},   // single process
        {11'd0,    10'd0,    1'b1, LONE_PROC},   // zero count reads as one
        {11'd0,    10'd1023, 1'b1, LONE_PROC},   // zero count and rank clamp
        {11'd1,    10'd1023, 1'b1, LONE_PROC},   // rank clamp
        {11'd2,    10'd1,    1'b1, PAIR_TOP},
        {11'd2,    10'd1023, 1'b1, PAIR_TOP},
        {11'd2,    10'd0,    1'b0, UNTYPED},
        {11'd2047, 10'd0,    1'b0, UNTYPED},     // count saturates
        {11'd1024, 10'd1023, 1'b0, UNTYPED},
        {11'd3,    10'd2,    1'b0, UNTYPED},
        {11'd4,    10'd3,    1'b0, UNTYPED},
        {11'd6,    10'd5,    1'b0, UNTYPED},
        {11'd8,    10'd7,    1'b0, UNTYPED},
        {11'd12,   10'd11,   1'b0, UNTYPED},
        {11'd12,   10'd6,    1'b0, UNTYPED},
        {11'd24,   10'd13,   1'b0, UNTYPED},
        {11'd27,   10'd26,   1'b0, UNTYPED},
        {11'd30,   10'd17,   1'b0, UNTYPED},
        {11'd36,   10'd0,    1'b0, UNTYPED},
        {11'd60,   10'd59,   1'b0, UNTYPED},
        {11'd64,   10'd63,   1'b0, UNTYPED},
        {11'd97,   10'd96,   1'b0, UNTYPED},
        {11'd512,  10'd341,  1'b0, UNTYPED}
    };

    proc_grid_factor_and_torus_neighbors uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic pgf_result_t grid_solution(input logic [CNT_W-1:0] count,
                                                  input logic [RANK_W-1:0] rank);
        int unsigned n, r, rem, iz, gx, gy, gz, slab, px, py, pz;
        logic [63:0]  face_xy, face_xz, face_yz;
        logic [127:0] cost, best;
        bit           found;
        pgf_result_t  res;
        n = 32'(count);
        if (n == 0)
            n = 1;
        if (n > MAX_PROCS)
            n = MAX_PROCS;
        r = 32'(rank);
        if (r >= n)
            r = n - 1;
        face_xy = 64'(ext_x) * 64'(ext_y);
        face_xz = 64'(ext_x) * 64'(ext_z);
        face_yz = 64'(ext_y) * 64'(ext_z);
        found = 1'b0;
        best  = '0;
        gx = 1;
        gy = 1;
        gz = 1;
        for (int unsigned ix = 1; ix <= n; ix++)
        begin
            if (n % ix == 0)
            begin
                rem = n / ix;
                for (int unsigned iy = 1; iy <= rem; iy++)
                begin
                    if (rem % iy == 0)
                    begin
                        iz = rem / iy;
                        cost = 128'(face_xy) * 128'(iz) + 128'(face_xz) * 128'(iy)
                             + 128'(face_yz) * 128'(ix);
                        // first strict minimum wins, ties keep the earlier grid
                        if (!found || cost < best)
                        begin
                            found = 1'b1;
                            best  = cost;
                            gx = ix;
                            gy = iy;
                            gz = iz;
                        end
                    end
                end
            end
        end
        slab = gx * gy;
        pz = r / slab;
        py = (r % slab) / gx;
        px = r % gx;
        res.grid_x = CNT_W'(gx);
        res.grid_y = CNT_W'(gy);
        res.grid_z = CNT_W'(gz);
        res.pos_x  = RANK_W'(px);
        res.pos_y  = RANK_W'(py);
        res.pos_z  = RANK_W'(pz);
        res.next_x = (gx > 1) ? CNT_W'((px < gx - 1) ? r + 1 : r - (gx - 1)) : NO_NEIGHBOR;
        res.prev_x = (gx > 1) ? CNT_W'((px > 0) ? r - 1 : r + (gx - 1)) : NO_NEIGHBOR;
        res.next_y = (gy > 1) ? CNT_W'((py < gy - 1) ? r + gx : r - gx * (gy - 1))
                              : NO_NEIGHBOR;
        res.prev_y = (gy > 1) ? CNT_W'((py > 0) ? r - gx : r + gx * (gy - 1)) : NO_NEIGHBOR;
        res.next_z = (gz > 1) ? CNT_W'((pz < gz - 1) ? r + slab : r - slab * (gz - 1))
                              : NO_NEIGHBOR;
        res.prev_z = (gz > 1) ? CNT_W'((pz > 0) ? r - slab : r + slab * (gz - 1))
                              : NO_NEIGHBOR;
        return res;
    endfunction

    function automatic pgf_result_t unpack_result(input logic [OUT_W-1:0] d);
        pgf_result_t res;
        res.grid_x = d[0 +: CNT_W];
        res.grid_y = d[CNT_W +: CNT_W];
        res.grid_z = d[2 * CNT_W +: CNT_W];
        res.pos_x  = d[3 * CNT_W +: RANK_W];
        res.pos_y  = d[3 * CNT_W + RANK_W +: RANK_W];
        res.pos_z  = d[3 * CNT_W + 2 * RANK_W +: RANK_W];
        res.next_x = d[NB_BASE +: CNT_W];
        res.prev_x = d[NB_BASE + CNT_W +: CNT_W];
        res.next_y = d[NB_BASE + 2 * CNT_W +: CNT_W];
        res.prev_y = d[NB_BASE + 3 * CNT_W +: CNT_W];
        res.next_z = d[NB_BASE + 4 * CNT_W +: CNT_W];
        res.prev_z = d[NB_BASE + 5 * CNT_W +: CNT_W];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic send_item(input logic [CNT_W-1:0] count, input logic [RANK_W-1:0] rank,
                             input logic typed, input pgf_result_t want);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({rank, count});
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        grids_pending.push_back(typed ? want : grid_solution(count, rank));
    endtask

    // bursts of back-to-back transfers separated by random gaps
    task automatic sender_gap();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 40);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (grids_pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [EXT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (index)
            REG_EXTENT_X: ext_x = value;
            REG_EXTENT_Y: ext_y = value;
            REG_EXTENT_Z: ext_z = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_extents(input logic [EXT_W-1:0] x, input logic [EXT_W-1:0] y,
                               input logic [EXT_W-1:0] z);
        write_reg(REG_EXTENT_X, x);
        write_reg(REG_EXTENT_Y, y);
        write_reg(REG_EXTENT_Z, z);
    endtask

    // mostly small counts since the divisor search grows with the count
    task automatic send_random();
        logic [CNT_W-1:0]  count;
        logic [RANK_W-1:0] rank;
        int sel;
        int eff;
        sel = $urandom_range(0, 99);
        if (sel < 88)
            count = CNT_W'($urandom_range(1, 64));
        else if (sel < 96)
            count = CNT_W'($urandom_range(65, MAX_PROCS));
        else if (sel < 98)
            count = '0;
        else
            count = CNT_W'($urandom_range(MAX_PROCS + 1, 2 ** CNT_W - 1));
        eff = (count == 0) ? 1 : ((count > MAX_PROCS) ? MAX_PROCS : int'(count));
        if ($urandom_range(0, 4) == 0)
            rank = RANK_W'($urandom);
        else
            rank = RANK_W'($urandom_range(0, eff - 1));
        send_item(count, rank, 1'b0, UNTYPED);
    endtask

    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(20, 400);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    3: m_axis_tready <= 1'b0;
                    default: m_axis_tready <= ($urandom_range(0, 15) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        pgf_result_t got;
        pgf_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            if (grids_pending.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result transfer with nothing pending: %h", m_axis_tdata);
            end
            else
            begin
                want = grids_pending.pop_front();
                check_field("grid_x", want.grid_x, got.grid_x);
                check_field("grid_y", want.grid_y, got.grid_y);
                check_field("grid_z", want.grid_z, got.grid_z);
                check_field("pos_x", CNT_W'(want.pos_x), CNT_W'(got.pos_x));
                check_field("pos_y", CNT_W'(want.pos_y), CNT_W'(got.pos_y));
                check_field("pos_z", CNT_W'(want.pos_z), CNT_W'(got.pos_z));
                check_field("next_x", want.next_x, got.next_x);
                check_field("prev_x", want.prev_x, got.prev_x);
                check_field("next_y", want.next_y, got.next_y);
                check_field("prev_y", want.prev_y, got.prev_y);
                check_field("next_z", want.next_z, got.next_z);
                check_field("prev_z", want.prev_z, got.prev_z);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset extents, directed rows
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_table[i].count, dir_table[i].rank, dir_table[i].typed,
                      dir_table[i].want);
            sender_gap();
        end
        wait_drained();

        for (int p = 0; p < EXT_PHASES; p++)
        begin
            case (p)
                0: set_extents(EXT_MAX, EXT_MAX, EXT_MAX);
                1:
                begin
                    set_extents(EXT_W'(1), EXT_W'(1), EXT_W'(1));
                    write_reg(REG_UNUSED, EXT_MAX);
                end
                // all costs tie at zero, the first candidate must stay
                2: set_extents('0, '0, '0);
                3: set_extents(EXT_MAX, EXT_W'(1), EXT_RESET);
                4: set_extents(EXT_W'($urandom), EXT_W'($urandom_range(1, 4096)),
                               EXT_W'($urandom));
                default: set_extents(EXT_RESET, EXT_RESET, EXT_RESET);
            endcase
            for (int k = 0; k < BATCH_ITEMS; k++)
            begin
                send_random();
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
                else
                    sender_gap();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && grids_pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
